// File: hdl/fifo_track_car_reorder_core_defines.svh
// Assertion macros for the car reorder block
`ifndef FIFO_TRACK_CAR_REORDER_CORE_DEFINES_SVH
`define FIFO_TRACK_CAR_REORDER_CORE_DEFINES_SVH

// Check cons in the cycle after ante
`define FTCR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ftcr: sequence check failed");

// Check cons in the same cycle as ante
`define FTCR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ftcr: result check failed");

`endif

// File: hdl/ftcr_pkg.sv
package ftcr_pkg;

    localparam int NUM_TRACKS_DEF  = 4;
    localparam int TRACK_DEPTH_DEF = 8;
    localparam int CAR_BITS_DEF    = 8;

    localparam int          CFG_W     = 3;
    localparam logic [2:0]  CFG_RESET = 3'd4;

    localparam int MAX_RESULTS = 33;
    localparam int K_W         = 6;

    typedef enum logic [1:0] {
        KIND_DIRECT = 2'd0,
        KIND_HOLD   = 2'd1,
        KIND_DRAIN  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        STAT_MOVED   = 2'd0,
        STAT_NO_ROOM = 2'd1,
        STAT_REJECT  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_PLACE,
        S_COMMIT,
        S_POP,
        S_LOAD,
        S_RESCAN,
        S_DRAIN
    } t_state;

    typedef struct packed {
        logic accept;
        logic place_init;
        logic place_step;
        logic commit;
        logic reject;
        logic direct;
        logic pop;
        logic load;
        logic rescan_step;
        logic drain;
        logic last;
    } t_cmd;

    typedef struct packed {
        logic failed;
        logic car_hit;
        logic drain_next;
        logic place_end;
        logic out_free;
    } t_stat;

endpackage

// File: hdl/ftcr_ram.sv
module ftcr_ram #(
    parameter int WIDTH = ftcr_pkg::CAR_BITS_DEF,
    parameter int DEPTH = ftcr_pkg::NUM_TRACKS_DEF * ftcr_pkg::TRACK_DEPTH_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                        i_wr_data,
    input  logic                                    i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                        o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hdl/ftcr_ctrl.sv
module ftcr_ctrl #(
    parameter int NUM_TRACKS = ftcr_pkg::NUM_TRACKS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  ftcr_pkg::t_stat       i_stat,
    output ftcr_pkg::t_cmd        o_cmd,
    output logic [((NUM_TRACKS > 1) ? $clog2(NUM_TRACKS) : 1)-1:0] o_idx
);

    localparam int IDX_W = (NUM_TRACKS > 1) ? $clog2(NUM_TRACKS) : 1;
    localparam int KW    = ftcr_pkg::K_W;

    ftcr_pkg::t_state r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [KW-1:0]    r_k, n_k;
    ftcr_pkg::t_cmd   cmd;
    logic             k_room;

    assign k_room = r_k < KW'(ftcr_pkg::MAX_RESULTS - 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ftcr_pkg::S_IDLE;
            r_idx   <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_k     <= n_k;
        end
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_k     = r_k;
        cmd     = '0;
        case (r_state)
            ftcr_pkg::S_IDLE: begin
                cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    n_state = ftcr_pkg::S_DECIDE;
                end
            end
            ftcr_pkg::S_DECIDE: begin
                if (i_stat.failed) begin
                    if (i_stat.out_free) begin
                        cmd.reject = 1'b1;
                        cmd.last   = 1'b1;
                        n_state    = ftcr_pkg::S_IDLE;
                    end
                end else if (i_stat.car_hit) begin
                    if (i_stat.out_free) begin
                        cmd.direct = 1'b1;
                        cmd.last   = !i_stat.drain_next;
                        n_k        = KW'(1);
                        n_state    = i_stat.drain_next ? ftcr_pkg::S_POP : ftcr_pkg::S_IDLE;
                    end
                end else begin
                    cmd.place_init = 1'b1;
                    n_idx          = '0;
                    n_state        = ftcr_pkg::S_PLACE;
                end
            end
            ftcr_pkg::S_PLACE: begin
                cmd.place_step = 1'b1;
                if (i_stat.place_end) begin
                    n_state = ftcr_pkg::S_COMMIT;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ftcr_pkg::S_COMMIT: begin
                if (i_stat.out_free) begin
                    cmd.commit = 1'b1;
                    cmd.last   = 1'b1;
                    n_state    = ftcr_pkg::S_IDLE;
                end
            end
            ftcr_pkg::S_POP: begin
                cmd.pop = 1'b1;
                n_state = ftcr_pkg::S_LOAD;
            end
            ftcr_pkg::S_LOAD: begin
                cmd.load = 1'b1;
                n_idx    = '0;
                n_state  = ftcr_pkg::S_RESCAN;
            end
            ftcr_pkg::S_RESCAN: begin
                cmd.rescan_step = 1'b1;
                if (r_idx == IDX_W'(NUM_TRACKS - 1)) begin
                    n_state = ftcr_pkg::S_DRAIN;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ftcr_pkg::S_DRAIN: begin
                if (i_stat.out_free) begin
                    cmd.drain = 1'b1;
                    cmd.last  = !(i_stat.drain_next && k_room);
                    n_k       = r_k + 1'b1;
                    n_state   = (i_stat.drain_next && k_room) ? ftcr_pkg::S_POP
                                                              : ftcr_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ftcr_pkg::S_IDLE;
            end
        endcase
    end

    assign o_cmd      = cmd;
    assign o_idx      = r_idx;
    assign o_in_ready = (r_state == ftcr_pkg::S_IDLE);

endmodule

// File: hdl/ftcr_dp.sv
module ftcr_dp #(
    parameter int NUM_TRACKS  = ftcr_pkg::NUM_TRACKS_DEF,
    parameter int TRACK_DEPTH = ftcr_pkg::TRACK_DEPTH_DEF,
    parameter int CAR_BITS    = ftcr_pkg::CAR_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ftcr_pkg::t_cmd        i_cmd,
    input  logic [((NUM_TRACKS > 1) ? $clog2(NUM_TRACKS) : 1)-1:0] i_idx,
    output ftcr_pkg::t_stat       o_stat,
    input  logic                  i_cfg_valid,
    input  logic [2:0]            i_cfg_tracks_in_use,
    input  logic [CAR_BITS-1:0]   i_car_number,
    input  logic                  i_new_train,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [CAR_BITS-1:0]   o_moved_car,
    output logic [1:0]            o_move_kind,
    output logic [1:0]            o_track_index,
    output logic [1:0]            o_status,
    output logic                  o_last_of_run
);

    localparam int IDX_W  = (NUM_TRACKS > 1) ? $clog2(NUM_TRACKS) : 1;
    localparam int PW     = (TRACK_DEPTH > 1) ? $clog2(TRACK_DEPTH) : 1;
    localparam int CW     = $clog2(TRACK_DEPTH + 1);
    localparam int MDEPTH = NUM_TRACKS * TRACK_DEPTH;
    localparam int AW     = (MDEPTH > 1) ? $clog2(MDEPTH) : 1;
    localparam int HW     = CAR_BITS + 1;
    localparam int CFW    = ftcr_pkg::CFG_W;
    localparam int LIM    = (NUM_TRACKS < 7) ? NUM_TRACKS : 7;
    localparam int EW     = (IDX_W > CFW) ? IDX_W : CFW;
    localparam logic [HW-1:0] NONE_HELD = HW'(1) << CAR_BITS;

    logic [CFW-1:0]      r_cfg;
    logic [CAR_BITS-1:0] r_car;
    logic [PW-1:0]       r_head  [NUM_TRACKS];
    logic [PW-1:0]       r_tail  [NUM_TRACKS];
    logic [CW-1:0]       r_count [NUM_TRACKS];
    logic [CAR_BITS-1:0] r_tval  [NUM_TRACKS];
    logic [CAR_BITS-1:0] r_front [NUM_TRACKS];
    logic [HW-1:0]       r_expected;
    logic [HW-1:0]       r_small;
    logic [IDX_W-1:0]    r_strk;
    logic                r_failed;
    logic                r_best_vld;
    logic [IDX_W-1:0]    r_best;
    logic [CAR_BITS-1:0] r_best_tail;
    logic                r_best_full;
    logic [CAR_BITS-1:0] r_drn_car;
    logic [IDX_W-1:0]    r_drn_trk;

    logic                r_out_valid;
    logic [CAR_BITS-1:0] r_out_car;
    ftcr_pkg::t_kind     r_out_kind;
    logic [1:0]          r_out_trk;
    ftcr_pkg::t_status   r_out_status;
    logic                r_out_last;

    logic [IDX_W-1:0]    sel;
    logic [PW-1:0]       head_sel, tail_sel, head_inc, tail_inc;
    logic [CW-1:0]       cnt_sel;
    logic [CAR_BITS-1:0] tval_sel, front_sel;
    logic                push_ok, emit;
    logic [CFW-1:0]      n_eff;
    logic [HW-1:0]       exp_inc;
    logic [AW-1:0]       wr_addr, rd_addr;
    logic [CAR_BITS-1:0] rd_data;

    always_comb begin
        if (i_cmd.commit) begin
            sel = r_best;
        end else if (i_cmd.pop) begin
            sel = r_strk;
        end else begin
            sel = i_idx;
        end
    end

    assign head_sel  = r_head[sel];
    assign tail_sel  = r_tail[sel];
    assign cnt_sel   = r_count[sel];
    assign tval_sel  = r_tval[sel];
    assign front_sel = r_front[sel];
    assign head_inc  = (head_sel == PW'(TRACK_DEPTH - 1)) ? '0 : head_sel + 1'b1;
    assign tail_inc  = (tail_sel == PW'(TRACK_DEPTH - 1)) ? '0 : tail_sel + 1'b1;
    assign push_ok   = r_best_vld && !r_best_full;
    assign exp_inc   = r_expected + 1'b1;
    assign emit      = i_cmd.reject || i_cmd.direct || i_cmd.commit || i_cmd.drain;

    assign n_eff = (r_cfg == '0) ? CFW'(1) : ((r_cfg > CFW'(LIM)) ? CFW'(LIM) : r_cfg);

    assign wr_addr = AW'(int'(r_best) * TRACK_DEPTH + int'(tail_sel));
    assign rd_addr = AW'(int'(r_strk) * TRACK_DEPTH + int'(head_inc));

    ftcr_ram #(
        .WIDTH (CAR_BITS),
        .DEPTH (MDEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.commit && push_ok),
        .i_wr_addr (wr_addr),
        .i_wr_data (r_car),
        .i_rd_en   (i_cmd.pop),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= ftcr_pkg::CFG_RESET;
            r_expected  <= HW'(1);
            r_small     <= NONE_HELD;
            r_strk      <= '0;
            r_failed    <= 1'b0;
            r_best_vld  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int t = 0; t < NUM_TRACKS; t++) begin
                r_head[t]  <= '0;
                r_tail[t]  <= '0;
                r_count[t] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_cfg <= i_cfg_tracks_in_use;
            end
            if (i_cmd.accept && i_new_train) begin
                r_expected <= HW'(1);
                r_small    <= NONE_HELD;
                r_strk     <= '0;
                r_failed   <= 1'b0;
                for (int t = 0; t < NUM_TRACKS; t++) begin
                    r_head[t]  <= '0;
                    r_tail[t]  <= '0;
                    r_count[t] <= '0;
                end
            end
            if (i_cmd.place_init) begin
                r_best_vld <= 1'b0;
            end
            if (i_cmd.place_step) begin
                if (cnt_sel != '0) begin
                    if (tval_sel > r_best_tail && tval_sel < r_car) begin
                        r_best_vld <= 1'b1;
                    end
                end else if (r_best_tail == '0) begin
                    r_best_vld <= 1'b1;
                end
            end
            if (i_cmd.direct || i_cmd.drain) begin
                r_expected <= exp_inc;
            end
            if (i_cmd.commit) begin
                if (!push_ok) begin
                    r_failed <= 1'b1;
                end else begin
                    r_tail[r_best]  <= tail_inc;
                    r_count[r_best] <= cnt_sel + 1'b1;
                    if ({1'b0, r_car} < r_small) begin
                        r_small <= {1'b0, r_car};
                        r_strk  <= r_best;
                    end
                end
            end
            if (i_cmd.pop && cnt_sel != '0) begin
                r_head[r_strk]  <= head_inc;
                r_count[r_strk] <= cnt_sel - 1'b1;
            end
            if (i_cmd.load) begin
                r_small <= NONE_HELD;
                r_strk  <= '0;
            end
            if (i_cmd.rescan_step && cnt_sel != '0 && {1'b0, front_sel} < r_small) begin
                r_small <= {1'b0, front_sel};
                r_strk  <= i_idx;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_car <= i_car_number;
        end
        if (i_cmd.place_init) begin
            r_best      <= '0;
            r_best_tail <= '0;
            r_best_full <= 1'b0;
        end
        if (i_cmd.place_step) begin
            if (cnt_sel != '0) begin
                if (tval_sel > r_best_tail && tval_sel < r_car) begin
                    r_best      <= i_idx;
                    r_best_tail <= tval_sel;
                    r_best_full <= (cnt_sel >= CW'(TRACK_DEPTH));
                end
            end else if (r_best_tail == '0) begin
                r_best      <= i_idx;
                r_best_full <= 1'b0;
            end
        end
        if (i_cmd.commit && push_ok) begin
            r_tval[r_best] <= r_car;
            if (cnt_sel == '0) begin
                r_front[r_best] <= r_car;
            end
        end
        if (i_cmd.pop) begin
            r_drn_car <= r_small[CAR_BITS-1:0];
            r_drn_trk <= r_strk;
        end
        if (i_cmd.load) begin
            r_front[r_drn_trk] <= rd_data;
        end
        if (emit) begin
            r_out_last <= i_cmd.last;
            if (i_cmd.reject) begin
                r_out_car    <= r_car;
                r_out_kind   <= ftcr_pkg::KIND_DIRECT;
                r_out_trk    <= '0;
                r_out_status <= ftcr_pkg::STAT_REJECT;
            end else if (i_cmd.direct) begin
                r_out_car    <= r_car;
                r_out_kind   <= ftcr_pkg::KIND_DIRECT;
                r_out_trk    <= '0;
                r_out_status <= ftcr_pkg::STAT_MOVED;
            end else if (i_cmd.commit) begin
                r_out_car    <= r_car;
                r_out_kind   <= ftcr_pkg::KIND_HOLD;
                r_out_trk    <= 2'(r_best);
                r_out_status <= push_ok ? ftcr_pkg::STAT_MOVED : ftcr_pkg::STAT_NO_ROOM;
            end else begin
                r_out_car    <= r_drn_car;
                r_out_kind   <= ftcr_pkg::KIND_DRAIN;
                r_out_trk    <= 2'(r_drn_trk);
                r_out_status <= ftcr_pkg::STAT_MOVED;
            end
        end
    end

    assign o_stat.failed     = r_failed;
    assign o_stat.car_hit    = ({1'b0, r_car} == r_expected);
    assign o_stat.drain_next = (r_small < NONE_HELD) && (r_small == exp_inc);
    assign o_stat.place_end  = (EW'(i_idx) == EW'(n_eff - 1'b1));
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_moved_car   = r_out_car;
    assign o_move_kind   = r_out_kind;
    assign o_track_index = r_out_trk;
    assign o_status      = r_out_status;
    assign o_last_of_run = r_out_last;

endmodule

// File: hdl/fifo_track_car_reorder_core.sv
// Car reordering through FIFO holding tracks.
// Input channel (i_in_valid / o_in_ready) takes one car number and a new-train flag;
// output channel (o_out_valid / i_out_ready) gives one item per move, the final item
// of a car marked by o_last_of_run. The config channel writes the number of holding
// tracks that placement may use; it is always ready. The user must write it only
// between cars; the block does not enforce it. A car is taken in the idle state only.
// Steps from the accept to the loading of each item:
//   rejected or straight-through car: the decide state
//   car placed on a track: decide, a scan of the tails of the tracks in use, commit
//   each drained car: pop, registered store read, front scan, drain
// The input is not ready again until the last item of a car is loaded, drains included.
// The output register lets the next car be taken while the last item waits.
// If the receiver stalls, the block holds in the state that owns the next item.
// Reset clears all tracks, the failure flag, sets the expected car to 1 and the
// track count to 4; the track store holds no reset and is read only where written.
module fifo_track_car_reorder_core #(
    parameter int NUM_TRACKS  = ftcr_pkg::NUM_TRACKS_DEF,
    parameter int TRACK_DEPTH = ftcr_pkg::TRACK_DEPTH_DEF,
    parameter int CAR_BITS    = ftcr_pkg::CAR_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_tracks_in_use,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [CAR_BITS-1:0] i_car_number,
    input  logic                i_new_train,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [CAR_BITS-1:0] o_moved_car,
    output logic [1:0]          o_move_kind,
    output logic [1:0]          o_track_index,
    output logic [1:0]          o_status,
    output logic                o_last_of_run
);

    localparam int IDX_W = (NUM_TRACKS > 1) ? $clog2(NUM_TRACKS) : 1;

    ftcr_pkg::t_cmd   cmd;
    ftcr_pkg::t_stat  stat;
    logic [IDX_W-1:0] idx;

    assign o_cfg_ready = 1'b1;

    ftcr_ctrl #(
        .NUM_TRACKS (NUM_TRACKS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_idx      (idx)
    );

    ftcr_dp #(
        .NUM_TRACKS  (NUM_TRACKS),
        .TRACK_DEPTH (TRACK_DEPTH),
        .CAR_BITS    (CAR_BITS)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .i_idx               (idx),
        .o_stat              (stat),
        .i_cfg_valid         (i_cfg_valid),
        .i_cfg_tracks_in_use (i_cfg_tracks_in_use),
        .i_car_number        (i_car_number),
        .i_new_train         (i_new_train),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_moved_car         (o_moved_car),
        .o_move_kind         (o_move_kind),
        .o_track_index       (o_track_index),
        .o_status            (o_status),
        .o_last_of_run       (o_last_of_run)
    );

endmodule

// File: hdl/ftcr_checker.sv
`include "fifo_track_car_reorder_core_defines.svh"

module ftcr_checker #(
    parameter int NUM_TRACKS  = ftcr_pkg::NUM_TRACKS_DEF,
    parameter int TRACK_DEPTH = ftcr_pkg::TRACK_DEPTH_DEF,
    parameter int CAR_BITS    = ftcr_pkg::CAR_BITS_DEF
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_cfg_valid,
    input logic                o_cfg_ready,
    input logic [2:0]          i_cfg_tracks_in_use,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic [CAR_BITS-1:0] i_car_number,
    input logic                i_new_train,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input logic [CAR_BITS-1:0] o_moved_car,
    input logic [1:0]          o_move_kind,
    input logic [1:0]          o_track_index,
    input logic [1:0]          o_status,
    input logic                o_last_of_run
);

    `FTCR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_moved_car) && $stable(o_last_of_run))
    `FTCR_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
    `FTCR_ASSERT_NOW(a_fail_ends_run, i_clk, i_rst_n, o_out_valid && o_status != ftcr_pkg::STAT_MOVED, o_last_of_run)
    `FTCR_ASSERT_NOW(a_mid_run_kind, i_clk, i_rst_n, o_out_valid && !o_last_of_run, o_move_kind == ftcr_pkg::KIND_DIRECT || o_move_kind == ftcr_pkg::KIND_DRAIN)

endmodule

bind fifo_track_car_reorder_core ftcr_checker #(
    .NUM_TRACKS  (NUM_TRACKS),
    .TRACK_DEPTH (TRACK_DEPTH),
    .CAR_BITS    (CAR_BITS)
) u_ftcr_checker (.*);
